@@ rtl/mcl_pkg.sv @@
// mcl_pkg: shared types, constants and codes of the mip chain layout unit
// used by mcl_alu and mip_chain_layout_unit; depends on nothing
`timescale 1ns / 1ps

package mcl_pkg;

   // chain limits
   localparam int MAX_LAYERS = 4;
   localparam int MAX_LEVELS = 15;
   localparam int MAX_DIM    = 16384;
   localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
   localparam int LAY_W      = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LCNT_W     = $clog2(MAX_LAYERS + 1);

   // shared unit widths
   localparam int ALU_A_W = 33;
   localparam int ALU_B_W = 16;
   localparam int ALU_P_W = ALU_A_W + ALU_B_W;
   localparam int ALU_N_W = 6;
   localparam int ALU_D_W = 7;

   // configuration register indexes
   localparam logic [1:0] CSR_BLOCK_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_BLOCK_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BLOCK_BYTES  = 2'd2;
   localparam logic [1:0] CSR_PIXEL_BITS   = 2'd3;

   typedef enum logic [0:0] {
      OP_MUL,
      OP_DIV
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RA,
      ST_AWDIV,
      ST_AWMUL,
      ST_PMUL,
      ST_PDIV,
      ST_PRMUL,
      ST_AHDIV,
      ST_AHMUL,
      ST_SMUL,
      ST_ZMUL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               start;
      alu_op_type         op;
      logic [ALU_N_W-1:0] nbits;
   } alu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_rsp_type;

endpackage

@@ rtl/mcl_alu.sv @@
// mcl_alu: shared iterative unit, shift-add multiply and restoring divide
// one bit per cycle over a single adder; depends on mcl_pkg
`timescale 1ns / 1ps

module mcl_alu import mcl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  alu_req_type        req_i,
   input  logic [ALU_A_W-1:0] a_i,
   input  logic [ALU_B_W-1:0] b_i,
   output alu_rsp_type        rsp_o,
   output logic [ALU_P_W-1:0] result_o
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   alu_op_type         op_ff, op_in;
   logic [ALU_N_W-1:0] cnt_ff, cnt_in;
   logic [ALU_P_W-1:0] acc_ff, acc_in;
   logic [ALU_P_W-1:0] mc_ff, mc_in;
   logic [ALU_B_W-1:0] mb_ff, mb_in;
   logic [ALU_A_W-1:0] dq_ff, dq_in;
   logic [ALU_D_W-1:0] rem_ff, rem_in;
   logic [ALU_D_W-1:0] dv_ff, dv_in;

   logic [ALU_D_W:0]   trial;
   logic [ALU_P_W-1:0] add_x, add_y, sum;
   logic               fits;
   logic [ALU_N_W-1:0] pre_sh;

   // the one adder: accumulate for multiply, trial subtract for divide
   always_comb begin
      trial = {rem_ff, dq_ff[ALU_A_W-1]};
      if (op_ff == OP_MUL) begin
         add_x = acc_ff;
         add_y = mb_ff[0] ? mc_ff : '0;
         sum   = add_x + add_y;
      end else begin
         add_x = {{(ALU_P_W-ALU_D_W-1){1'b0}}, trial};
         add_y = ~{{(ALU_P_W-ALU_D_W){1'b0}}, dv_ff};
         sum   = add_x + add_y + {{(ALU_P_W-1){1'b0}}, 1'b1};
      end
      fits   = ~sum[ALU_P_W-1];
      pre_sh = ALU_N_W'(ALU_A_W) - req_i.nbits;
   end

   // sequencing of one operation
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mb_in   = mb_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      if (req_i.start) begin
         busy_in = 1'b1;
         op_in   = req_i.op;
         cnt_in  = req_i.nbits;
         acc_in  = '0;
         mc_in   = {{ALU_B_W{1'b0}}, a_i};
         mb_in   = b_i;
         dq_in   = a_i << pre_sh;
         rem_in  = '0;
         dv_in   = b_i[ALU_D_W-1:0];
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ALU_N_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (op_ff == OP_MUL) begin
            acc_in = sum;
            mc_in  = mc_ff << 1;
            mb_in  = mb_ff >> 1;
         end else begin
            rem_in = fits ? sum[ALU_D_W-1:0] : trial[ALU_D_W-1:0];
            dq_in  = {dq_ff[ALU_A_W-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mb_ff  <= mb_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
   end

   assign rsp_o.busy = busy_ff;
   assign rsp_o.done = done_ff;
   assign result_o   = (op_ff == OP_MUL) ? acc_ff : {{ALU_B_W{1'b0}}, dq_ff};

endmodule

@@ rtl/mip_chain_layout_unit.sv @@
// mip_chain_layout_unit: one request in, one descriptor item per plane out
// per-level arithmetic runs on the iterative mcl_alu; depends on mcl_pkg, mcl_alu
// a row alignment divide, then per level a run of bit-serial multiplies and divides, then
// one plane item per cycle from the level table while the output is not stalled; one
// request at a time, req_tready high only when idle
// reset: synchronous, control cleared and configuration back to its reset values
`timescale 1ns / 1ps

module mip_chain_layout_unit import mcl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // base_width, base_height, base_depth, pixel_step, min_pitch, min_slice,
   // layer_count, level_count, level_outer
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // layer, level, plane_offset, plane_width, plane_height, plane_depth,
   // row_pitch, slice_bytes, plane_bytes, overflow
   output logic [183:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data
);

   state_type state_ff, state_in;
   logic      issue_ff, issue_in;

   logic [4:0] bw_ff, bh_ff;
   logic [6:0] bb_ff;
   logic [7:0] pb_ff;

   logic [14:0]       w_ff, h_ff, w_in, h_in;
   logic [11:0]       d_ff, d_in;
   logic [7:0]        step_ff, step_in;
   logic [31:0]       mp_ff, ms_ff, mp_in, ms_in;
   logic [LCNT_W-1:0] layers_ff, layers_in;
   logic [LVL_W-1:0]  levels_ff, levels_in;
   logic              mip_ff, mip_in;
   logic [6:0]        ra_ff, ra_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [32:0]       num_ff, num_in;
   logic [31:0]       pitch_ff, pitch_in, slice_ff, slice_in;
   logic              lovf_ff, lovf_in;

   logic [31:0] tbl_pitch_ff [MAX_LEVELS];
   logic [31:0] tbl_slice_ff [MAX_LEVELS];
   logic [31:0] tbl_size_ff  [MAX_LEVELS];
   logic        tbl_ovf_ff   [MAX_LEVELS];
   logic        tbl_we;

   logic [LVL_W-1:0] outer_ff, outer_in, inner_ff, inner_in;
   logic [31:0]      offset_ff, offset_in;
   logic             sticky_ff, sticky_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [183:0] rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;

   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;
   logic [ALU_A_W-1:0] alu_a;
   logic [ALU_B_W-1:0] alu_b;
   logic [ALU_P_W-1:0] alu_res;

   logic        req_acc, load;
   logic [4:0]  bw_e, bh_e;
   logic [14:0] wl, hl, em_w, em_h;
   logic [11:0] dl, em_d;
   logic [LVL_W-1:0] outer_n, inner_n, em_lvl, full;
   logic [LAY_W-1:0] em_layer;
   logic        em_last, last_level;
   logic [31:0] p_val, s_val;
   logic [32:0] off_sum;
   logic        sticky_new;

   logic [14:0] in_w, in_h;
   logic [11:0] in_d;
   logic [2:0]  in_layers;
   logic [3:0]  in_levels;

   function automatic logic [3:0] msb15(input logic [14:0] v);
      logic [3:0] r;
      r = 4'd0;
      for (int i = 0; i < 15; i++) begin
         if (v[i]) r = i[3:0];
      end
      return r;
   endfunction

   function automatic logic [14:0] sat15(input logic [14:0] v);
      logic [14:0] r;
      r = v;
      if (v == 15'd0) r = 15'd1;
      else if (v > 15'(MAX_DIM)) r = 15'(MAX_DIM);
      return r;
   endfunction

   mcl_alu u_alu (
      .clock    (clock),
      .reset    (reset),
      .req_i    (alu_req),
      .a_i      (alu_a),
      .b_i      (alu_b),
      .rsp_o    (alu_rsp),
      .result_o (alu_res)
   );

   // handshakes and common terms
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign load       = (state_ff == ST_EMIT) & (~rsp_valid_ff | rsp_tready);
   assign bw_e       = (bw_ff == 5'd0) ? 5'd1 : bw_ff;
   assign bh_e       = (bh_ff == 5'd0) ? 5'd1 : bh_ff;
   assign last_level = (lvl_ff == levels_ff - 1'b1);

   // level dimensions by halving, never below one
   always_comb begin
      wl   = w_ff >> lvl_ff;
      hl   = h_ff >> lvl_ff;
      dl   = d_ff >> lvl_ff;
      wl   = (wl == 15'd0) ? 15'd1 : wl;
      hl   = (hl == 15'd0) ? 15'd1 : hl;
      dl   = (dl == 12'd0) ? 12'd1 : dl;
      em_w = w_ff >> em_lvl;
      em_h = h_ff >> em_lvl;
      em_d = d_ff >> em_lvl;
      em_w = (em_w == 15'd0) ? 15'd1 : em_w;
      em_h = (em_h == 15'd0) ? 15'd1 : em_h;
      em_d = (em_d == 12'd0) ? 12'd1 : em_d;
   end

   // request decode: saturation and chain length
   always_comb begin
      in_w      = sat15(req_tdata[14:0]);
      in_h      = sat15(req_tdata[29:15]);
      in_d      = (req_tdata[41:30] == 12'd0) ? 12'd1 : req_tdata[41:30];
      full      = LVL_W'(msb15(in_w)) + 1'b1;
      if (LVL_W'(msb15(in_h)) + 1'b1 > full) full = LVL_W'(msb15(in_h)) + 1'b1;
      if (LVL_W'(msb15({3'd0, in_d})) + 1'b1 > full) full = LVL_W'(msb15({3'd0, in_d})) + 1'b1;
      in_layers = req_tdata[116:114];
      in_levels = req_tdata[120:117];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc) state_in = ST_RA;
         ST_RA:    if (alu_rsp.done) state_in = ST_AWDIV;
         ST_AWDIV: if (alu_rsp.done) state_in = ST_AWMUL;
         ST_AWMUL: if (alu_rsp.done) state_in = ST_PMUL;
         ST_PMUL:  if (alu_rsp.done) state_in = ST_PDIV;
         ST_PDIV:  if (alu_rsp.done) state_in = ST_PRMUL;
         ST_PRMUL: if (alu_rsp.done) state_in = ST_AHDIV;
         ST_AHDIV: if (alu_rsp.done) state_in = ST_AHMUL;
         ST_AHMUL: if (alu_rsp.done) state_in = ST_SMUL;
         ST_SMUL:  if (alu_rsp.done) state_in = ST_ZMUL;
         ST_ZMUL: begin
            if (alu_rsp.done) state_in = last_level ? ST_EMIT : ST_AWDIV;
         end
         ST_EMIT:  if (load && em_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // operand selection for the shared unit
   always_comb begin
      alu_req.start = issue_ff;
      alu_req.op    = OP_MUL;
      alu_req.nbits = ALU_N_W'(1);
      alu_a         = alu_res[ALU_A_W-1:0];
      alu_b         = '0;
      case (state_ff)
         ST_RA: begin
            alu_req.op    = OP_DIV;
            alu_req.nbits = ALU_N_W'(7);
            alu_a         = {26'd0, bb_ff};
            alu_b         = {11'd0, bh_e};
         end
         ST_AWDIV: begin
            alu_req.op    = OP_DIV;
            alu_req.nbits = ALU_N_W'(15);
            alu_a         = {18'd0, wl} + {28'd0, bw_e} - 33'd1;
            alu_b         = {11'd0, bw_e};
         end
         ST_AWMUL: begin
            alu_req.nbits = ALU_N_W'(5);
            alu_b         = {11'd0, bw_e};
         end
         ST_PMUL: begin
            alu_req.nbits = ALU_N_W'(8);
            alu_b         = {8'd0, step_ff};
         end
         ST_PDIV: begin
            alu_req.op    = OP_DIV;
            alu_req.nbits = ALU_N_W'(33);
            alu_a         = num_ff;
            alu_b         = {9'd0, ra_ff};
         end
         ST_PRMUL: begin
            alu_req.nbits = ALU_N_W'(7);
            alu_b         = {9'd0, ra_ff};
         end
         ST_AHDIV: begin
            alu_req.op    = OP_DIV;
            alu_req.nbits = ALU_N_W'(15);
            alu_a         = {18'd0, hl} + {28'd0, bh_e} - 33'd1;
            alu_b         = {11'd0, bh_e};
         end
         ST_AHMUL: begin
            alu_req.nbits = ALU_N_W'(5);
            alu_b         = {11'd0, bh_e};
         end
         ST_SMUL: begin
            alu_req.nbits = ALU_N_W'(15);
            alu_a         = {1'b0, pitch_ff};
            alu_b         = {1'b0, alu_res[14:0]};
         end
         ST_ZMUL: begin
            alu_req.nbits = ALU_N_W'(12);
            alu_a         = {1'b0, slice_ff};
            alu_b         = {4'd0, dl};
         end
         default: alu_req.start = 1'b0;
      endcase
   end

   // plane order
   always_comb begin
      outer_n  = mip_ff ? levels_ff : LVL_W'(layers_ff);
      inner_n  = mip_ff ? LVL_W'(layers_ff) : levels_ff;
      em_lvl   = mip_ff ? outer_ff : inner_ff;
      em_layer = mip_ff ? inner_ff[LAY_W-1:0] : outer_ff[LAY_W-1:0];
      em_last  = (outer_ff == outer_n - 1'b1) && (inner_ff == inner_n - 1'b1);
   end

   // per-level values and plane emission
   always_comb begin
      issue_in  = req_acc | (alu_rsp.done & (state_in != ST_EMIT));
      w_in      = w_ff;
      h_in      = h_ff;
      d_in      = d_ff;
      step_in   = step_ff;
      mp_in     = mp_ff;
      ms_in     = ms_ff;
      layers_in = layers_ff;
      levels_in = levels_ff;
      mip_in    = mip_ff;
      ra_in     = ra_ff;
      lvl_in    = lvl_ff;
      num_in    = num_ff;
      pitch_in  = pitch_ff;
      slice_in  = slice_ff;
      lovf_in   = lovf_ff;
      tbl_we    = 1'b0;
      outer_in  = outer_ff;
      inner_in  = inner_ff;
      offset_in = offset_ff;
      sticky_in = sticky_ff;
      p_val     = alu_res[34:3];
      s_val     = alu_res[31:0];
      if (lvl_ff == '0 && mp_ff > p_val) p_val = mp_ff;
      if (lvl_ff == '0 && ms_ff > s_val) s_val = ms_ff;
      if (req_acc) begin
         w_in      = in_w;
         h_in      = in_h;
         d_in      = in_d;
         step_in   = (req_tdata[49:42] < pb_ff) ? pb_ff : req_tdata[49:42];
         mp_in     = req_tdata[81:50];
         ms_in     = req_tdata[113:82];
         layers_in = (in_layers == 3'd0) ? LCNT_W'(1) :
                     (in_layers > 3'(MAX_LAYERS)) ? LCNT_W'(MAX_LAYERS) : LCNT_W'(in_layers);
         levels_in = (in_levels == 4'd0 || LVL_W'(in_levels) > full) ? full : LVL_W'(in_levels);
         if (levels_in > LVL_W'(MAX_LEVELS)) levels_in = LVL_W'(MAX_LEVELS);
         mip_in    = req_tdata[121];
         lvl_in    = '0;
         outer_in  = '0;
         inner_in  = '0;
         offset_in = '0;
         sticky_in = 1'b0;
      end
      if (alu_rsp.done) begin
         case (state_ff)
            ST_RA:    ra_in = (alu_res[6:0] == 7'd0) ? 7'd1 : alu_res[6:0];
            ST_PMUL:  num_in = {1'b0, p_val} + {26'd0, ra_ff} - 33'd1;
            ST_PRMUL: begin
               pitch_in = alu_res[31:0];
               lovf_in  = |alu_res[ALU_P_W-1:32];
            end
            ST_SMUL: begin
               slice_in = s_val;
               lovf_in  = lovf_ff | (|alu_res[ALU_P_W-1:32]);
            end
            ST_ZMUL: begin
               tbl_we = 1'b1;
               lvl_in = lvl_ff + 1'b1;
            end
            default: ;
         endcase
      end
      sticky_new = sticky_ff | tbl_ovf_ff[em_lvl];
      off_sum    = {1'b0, offset_ff} + {1'b0, tbl_size_ff[em_lvl]};
      if (load) begin
         offset_in = off_sum[31:0];
         sticky_in = sticky_new | off_sum[32];
         if (inner_ff == inner_n - 1'b1) begin
            inner_in = '0;
            outer_in = outer_ff + 1'b1;
         end else begin
            inner_in = inner_ff + 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = em_last;
         rsp_data_in  = {7'd0, sticky_new, tbl_size_ff[em_lvl], tbl_slice_ff[em_lvl],
                         tbl_pitch_ff[em_lvl], em_d, em_h, em_w, offset_ff,
                         4'(em_lvl), 2'(em_layer)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bw_ff        <= 5'd1;
         bh_ff        <= 5'd1;
         bb_ff        <= 7'd4;
         pb_ff        <= 8'd32;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BLOCK_WIDTH:  bw_ff <= csr_data[4:0];
               CSR_BLOCK_HEIGHT: bh_ff <= csr_data[4:0];
               CSR_BLOCK_BYTES:  bb_ff <= csr_data[6:0];
               CSR_PIXEL_BITS:   pb_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      d_ff        <= d_in;
      step_ff     <= step_in;
      mp_ff       <= mp_in;
      ms_ff       <= ms_in;
      layers_ff   <= layers_in;
      levels_ff   <= levels_in;
      mip_ff      <= mip_in;
      ra_ff       <= ra_in;
      lvl_ff      <= lvl_in;
      num_ff      <= num_in;
      pitch_ff    <= pitch_in;
      slice_ff    <= slice_in;
      lovf_ff     <= lovf_in;
      outer_ff    <= outer_in;
      inner_ff    <= inner_in;
      offset_ff   <= offset_in;
      sticky_ff   <= sticky_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (tbl_we) begin
         tbl_pitch_ff[lvl_ff] <= pitch_ff;
         tbl_slice_ff[lvl_ff] <= slice_ff;
         tbl_size_ff[lvl_ff]  <= alu_res[31:0];
         tbl_ovf_ff[lvl_ff]   <= lovf_ff | (|alu_res[ALU_P_W-1:32]);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> !alu_rsp.busy)
      else $error("shared unit started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> $past(alu_rsp.busy))
      else $error("shared unit done without work");
   a_emit_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (em_lvl < levels_ff))
      else $error("emitted level outside chain");
`endif

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for mip_chain_layout_unit, a directed table, then directed rows
// and random requests under several register settings, each plane item checked against a typed
// expected item or an in-bench layout predictor; depends on mcl_pkg and mip_chain_layout_unit
`timescale 1ns / 1ps

module tb_top import mcl_pkg::*; ();

   typedef struct {
      logic [14:0] base_width;
      logic [14:0] base_height;
      logic [11:0] base_depth;
      logic [7:0]  pixel_step;
      logic [31:0] min_pitch;
      logic [31:0] min_slice;
      logic [2:0]  layer_count;
      logic [3:0]  level_count;
      logic        level_outer;
   } layout_req_type;

   typedef struct {
      logic [1:0]  layer;
      logic [3:0]  level;
      logic [31:0] plane_offset;
      logic [14:0] plane_width;
      logic [14:0] plane_height;
      logic [11:0] plane_depth;
      logic [31:0] row_pitch;
      logic [31:0] slice_bytes;
      logic [31:0] plane_bytes;
      logic        overflow;
      logic        last;
   } plane_desc_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // base_width, base_height, base_depth, pixel_step, min_pitch, min_slice,
   // layer_count, level_count, level_outer
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // layer, level, plane_offset, plane_width, plane_height, plane_depth,
   // row_pitch, slice_bytes, plane_bytes, overflow
   logic [183:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [7:0]   csr_data = '0;

   // shadow copy of the configuration registers
   logic [4:0]   cfg_block_width;
   logic [4:0]   cfg_block_height;
   logic [6:0]   cfg_block_bytes;
   logic [7:0]   cfg_pixel_bits;

   plane_desc_type pending_planes[$];
   int             error_count = 0;
   int             burst_left = 0;

   mip_chain_layout_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic longint unsigned round_up(longint unsigned v, longint unsigned m);
      return (v + m - 1) / m * m;
   endfunction

   function automatic logic [31:0] wrap32(longint unsigned v, inout logic ovf);
      if (v > 64'hFFFF_FFFF) ovf = 1'b1;
      return v[31:0];
   endfunction

   function automatic int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   // computes every plane of one request and queues the descriptors in emit order
   function automatic void predict_layout(layout_req_type r);
      int unsigned     lw[MAX_LEVELS], lh[MAX_LEVELS], ld[MAX_LEVELS];
      logic [31:0]     lpitch[MAX_LEVELS], lslice[MAX_LEVELS], lsize[MAX_LEVELS];
      logic            lovf[MAX_LEVELS];
      int unsigned     w, h, d, tw, th, td, step, layers, levels, full, n_out, n_in, k, total;
      longint unsigned bw, bh, ra, aw, ah, p, offset;
      logic [31:0]     s, mp, ms;
      logic            sticky, ovf;
      plane_desc_type  pd;
      w = clamp_dim(r.base_width);
      h = clamp_dim(r.base_height);
      d = clamp_dim(r.base_depth);
      step = (r.pixel_step < cfg_pixel_bits) ? cfg_pixel_bits : r.pixel_step;
      layers = (r.layer_count == 0) ? 1 : r.layer_count;
      if (layers > MAX_LAYERS) layers = MAX_LAYERS;
      bw = (cfg_block_width == 0) ? 1 : cfg_block_width;
      bh = (cfg_block_height == 0) ? 1 : cfg_block_height;
      ra = cfg_block_bytes / bh;
      if (ra == 0) ra = 1;
      // full chain length: halve until every dimension is 1
      full = 1; tw = w; th = h; td = d;
      while (tw > 1 || th > 1 || td > 1) begin
         if (tw > 1) tw >>= 1;
         if (th > 1) th >>= 1;
         if (td > 1) td >>= 1;
         full++;
      end
      levels = r.level_count;
      if (levels == 0 || levels > full) levels = full;
      if (levels > MAX_LEVELS) levels = MAX_LEVELS;
      // per-level table; only the base level sees the minimums
      for (int a = 0; a < levels; a++) begin
         mp = (a == 0) ? r.min_pitch : 32'd0;
         ms = (a == 0) ? r.min_slice : 32'd0;
         lw[a] = w; lh[a] = h; ld[a] = d;
         ovf = 1'b0;
         aw = round_up(w, bw);
         ah = round_up(h, bh);
         p = aw * step / 8;
         if (p < mp) p = mp;
         lpitch[a] = wrap32(round_up(p, ra), ovf);
         s = wrap32(longint'(lpitch[a]) * ah, ovf);
         if (s < ms) s = ms;
         lslice[a] = s;
         lsize[a] = wrap32(longint'(s) * d, ovf);
         lovf[a] = ovf;
         if (w > 1) w >>= 1;
         if (h > 1) h >>= 1;
         if (d > 1) d >>= 1;
      end
      // emit in layer-major or mip-major order with running offset
      total = layers * levels;
      n_out = r.level_outer ? levels : layers;
      n_in = r.level_outer ? layers : levels;
      k = 0; offset = 0; sticky = 1'b0;
      for (int a = 0; a < n_out; a++) begin
         for (int b = 0; b < n_in; b++) begin
            pd.layer = 2'(r.level_outer ? b : a);
            pd.level = 4'(r.level_outer ? a : b);
            sticky = sticky | lovf[pd.level];
            pd.plane_offset = offset[31:0];
            pd.plane_width = 15'(lw[pd.level]);
            pd.plane_height = 15'(lh[pd.level]);
            pd.plane_depth = 12'(ld[pd.level]);
            pd.row_pitch = lpitch[pd.level];
            pd.slice_bytes = lslice[pd.level];
            pd.plane_bytes = lsize[pd.level];
            pd.overflow = sticky;
            pd.last = (k + 1 == total);
            pending_planes = {pending_planes, pd};
            offset += lsize[pd.level];
            if (offset > 64'hFFFF_FFFF) begin
               sticky = 1'b1;
               offset &= 64'hFFFF_FFFF;
            end
            k++;
         end
      end
   endfunction

   function automatic layout_req_type mk_req(int w, int h, int d, int step, logic [31:0] mp,
                                             logic [31:0] ms, int lay, int lvl, bit mm);
      layout_req_type r;
      r.base_width = 15'(w); r.base_height = 15'(h); r.base_depth = 12'(d);
      r.pixel_step = 8'(step);
      r.min_pitch = mp; r.min_slice = ms; r.layer_count = 3'(lay); r.level_count = 4'(lvl);
      r.level_outer = mm;
      return r;
   endfunction

   function automatic plane_desc_type mk_plane(logic [31:0] pitch, logic [31:0] slice,
                                               logic [31:0] size, bit ovf);
      plane_desc_type p;
      p.layer = 0; p.level = 0; p.plane_offset = 0;
      p.plane_width = 1; p.plane_height = 1; p.plane_depth = 1;
      p.row_pitch = pitch; p.slice_bytes = slice; p.plane_bytes = size;
      p.overflow = ovf; p.last = 1'b1;
      return p;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // configuration write, only issued while the block is idle
   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BLOCK_WIDTH:  cfg_block_width = val[4:0];
         CSR_BLOCK_HEIGHT: cfg_block_height = val[4:0];
         CSR_BLOCK_BYTES:  cfg_block_bytes = val[6:0];
         CSR_PIXEL_BITS:   cfg_pixel_bits = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(logic [7:0] bw, logic [7:0] bh, logic [7:0] bb, logic [7:0] pb);
      write_csr(CSR_BLOCK_WIDTH, bw);
      write_csr(CSR_BLOCK_HEIGHT, bh);
      write_csr(CSR_BLOCK_BYTES, bb);
      write_csr(CSR_PIXEL_BITS, pb);
   endtask

   // offers one request, honoring the burst and gap pattern of the sender
   task automatic send_req(layout_req_type r, bit typed, plane_desc_type exp_p);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_tdata <= {6'd0, r.level_outer, r.level_count, r.layer_count, r.min_slice,
                    r.min_pitch, r.pixel_step, r.base_depth, r.base_height, r.base_width};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (typed) pending_planes = {pending_planes, exp_p};
      else predict_layout(r);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_planes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return $urandom_range(0, 4096);
         2: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic int rand_dim(int hi_small);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 80) return $urandom_range(0, hi_small);
      if (sel < 95) return $urandom_range(0, 2048);
      return $urandom_range(0, 32767);
   endfunction

   // stimulus: directed table, then extreme-setting and random phases under varied settings
   initial begin
      layout_req_type dir_reqs[$];
      bit             dir_typed[$];
      plane_desc_type dir_exp[$];
      plane_desc_type none_p;
      layout_req_type r;
      none_p = mk_plane(0, 0, 0, 0);
      cfg_block_width = 1; cfg_block_height = 1; cfg_block_bytes = 4; cfg_pixel_bits = 32;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under reset settings
      dir_reqs = {dir_reqs, mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0)};
      dir_typed = {dir_typed, 1'b1}; dir_exp = {dir_exp, mk_plane(4, 4, 4, 0)};
      // pitch rounding wraps past 32 bits
      dir_reqs = {dir_reqs, mk_req(1, 1, 1, 0, 32'hFFFF_FFFF, 0, 1, 1, 0)};
      dir_typed = {dir_typed, 1'b1}; dir_exp = {dir_exp, mk_plane(0, 0, 0, 1)};
      // slice minimum at its top
      dir_reqs = {dir_reqs, mk_req(1, 1, 1, 0, 0, 32'hFFFF_FFFF, 1, 0, 1)};
      dir_typed = {dir_typed, 1'b1};
      dir_exp = {dir_exp, mk_plane(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0)};
      dir_reqs = {dir_reqs, mk_req(16384, 16384, 2048, 255, 0, 0, 4, 0, 0)};
      dir_reqs = {dir_reqs, mk_req(16384, 16384, 2048, 255, 0, 0, 4, 0, 1)};
      // oversize dimensions saturate
      dir_reqs = {dir_reqs, mk_req(32767, 32767, 4095, 8, 0, 0, 1, 15, 0)};
      // too many layers
      dir_reqs = {dir_reqs, mk_req(8, 4, 2, 64, 100, 1000, 7, 0, 1)};
      // level count above the full chain length
      dir_reqs = {dir_reqs, mk_req(5, 3, 0, 0, 0, 0, 2, 15, 0)};
      dir_reqs = {dir_reqs, mk_req(16384, 16384, 1, 32, 0, 0, 4, 1, 0)};
      dir_reqs = {dir_reqs,
                  mk_req(12345, 1, 1, 255, 32'h8000_0001, 32'h7FFF_FFFF, 3, 3, 1)};
      dir_reqs = {dir_reqs, mk_req(1, 16384, 4095, 128, 0, 0, 4, 14, 0)};
      for (int i = 0; i < dir_reqs.size(); i++) begin
         if (i < dir_typed.size()) send_req(dir_reqs[i], dir_typed[i], dir_exp[i]);
         else send_req(dir_reqs[i], 0, none_p);
      end

      // extreme settings, several directed rows each
      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         case (ph)
            0: set_config(0, 0, 0, 0);
            1: set_config(31, 31, 127, 255);
            2: set_config(16, 16, 64, 128);
            default: set_config(4, 8, 3, 1);
         endcase
         send_req(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_p);
         send_req(mk_req(16384, 16384, 2048, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4, 0,
                         ph[0]), 0, none_p);
         send_req(mk_req(37, 19, 5, 12, 0, 0, 2, 0, 1), 0, none_p);
      end

      // random phases
      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         if (ph == 0) set_config(1, 1, 4, 32);
         else set_config(8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                         8'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
         for (int n = 0; n < 45; n++) begin
            r = mk_req(rand_dim(70), rand_dim(70), ($urandom_range(0, 9) < 7) ?
                       $urandom_range(0, 3) : $urandom_range(0, 4095),
                       $urandom_range(0, 255), rand_word(), rand_word(),
                       $urandom_range(0, 7), $urandom_range(0, 15),
                       1'($urandom_range(0, 1)));
            send_req(r, 0, none_p);
         end
      end

      // drain and report
      wait_idle();
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: changing stall pattern, plus one long hold-off
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 64 == 0) mode = $urandom_range(0, 3);
         if (cyc >= 30000 && cyc < 31500) rsp_tready <= 1'b0;
         else case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2: rsp_tready <= (cyc % 5 != 0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      plane_desc_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_planes.size() == 0) begin
            $display("%0t ns: plane item expected none actual %0h", $time, rsp_tdata);
            error_count++;
         end else begin
            e = pending_planes.pop_front();
            check_field("layer", e.layer, rsp_tdata[1:0]);
            check_field("level", e.level, rsp_tdata[5:2]);
            check_field("plane_offset", e.plane_offset, rsp_tdata[37:6]);
            check_field("plane_width", e.plane_width, rsp_tdata[52:38]);
            check_field("plane_height", e.plane_height, rsp_tdata[67:53]);
            check_field("plane_depth", e.plane_depth, rsp_tdata[79:68]);
            check_field("row_pitch", e.row_pitch, rsp_tdata[111:80]);
            check_field("slice_bytes", e.slice_bytes, rsp_tdata[143:112]);
            check_field("plane_bytes", e.plane_bytes, rsp_tdata[175:144]);
            check_field("overflow", e.overflow, rsp_tdata[176]);
            check_field("last", e.last, rsp_tlast);
         end
      end
   end

   // watchdog
   initial begin
      #400_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
